/* rtl/core/mafl_pkg.sv */
// ----------------------------------------------------------------------------
// mafl_pkg: constants and lookup tables for the MPEG audio frame length block
// Holds header field codes, the bitrate and sample rate tables, the length
// multipliers and the reciprocal table used for the exact divide by the rate.
// ----------------------------------------------------------------------------
`default_nettype none

package mafl_pkg;

  localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

  // Version codes.
  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSV    = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  // Layer codes.
  localparam logic [1:0] LAYER_RSV = 2'd0;
  localparam logic [1:0] LAYER_III = 2'd1;
  localparam logic [1:0] LAYER_II  = 2'd2;
  localparam logic [1:0] LAYER_I   = 2'd3;

  // Field widths.
  localparam int KBPS_W  = 9;
  localparam int HZ_W    = 16;
  localparam int MULT_W  = 18;
  localparam int RECIP_W = 14;
  localparam int NUM_W   = 26;
  localparam int QUOT_W  = 12;
  localparam int LEN_W   = 12;

  // The numerator stays below 2**DIV_SHIFT, so a floored reciprocal scaled by
  // 2**DIV_SHIFT gives a quotient estimate that is low by at most one.
  localparam int DIV_SHIFT = NUM_W;
  localparam int PROD_W    = NUM_W + RECIP_W;

  // Length multipliers: 12000 for Layer I, 125 times the samples per frame else.
  localparam logic [MULT_W-1:0] MULT_L1    = 18'd12000;
  localparam logic [MULT_W-1:0] MULT_1152  = 18'd144000;
  localparam logic [MULT_W-1:0] MULT_576   = 18'd72000;

  localparam logic [KBPS_W-1:0] KBPS_TAB [0:4][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [HZ_W-1:0] HZ_TAB [0:3][0:3] = '{
    '{16'd11025, 16'd12000, 16'd8000, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  // floor(2**DIV_SHIFT / rate) for each rate in HZ_TAB.
  localparam logic [RECIP_W-1:0] RECIP_TAB [0:3][0:3] = '{
    '{14'd6086, 14'd5592, 14'd8388, 14'd0},
    '{14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd3043, 14'd2796, 14'd4194, 14'd0},
    '{14'd1521, 14'd1398, 14'd2097, 14'd0}
  };

  function automatic logic [KBPS_W-1:0] lookup_kbps(input logic [1:0] ver,
                                                    input logic [1:0] lay,
                                                    input logic [3:0] idx);
    logic [2:0] row;
    row = 3'd4;
    if (ver == VER_MPEG1) begin
      case (lay)
        LAYER_I:  row = 3'd0;
        LAYER_II: row = 3'd1;
        default:  row = 3'd2;
      endcase
    end else begin
      row = (lay == LAYER_I) ? 3'd3 : 3'd4;
    end
    if (lay == LAYER_RSV || ver == VER_RSV) begin
      return '0;
    end
    return KBPS_TAB[row][idx];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mpeg_audio_frame_length_top.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_length_top: MPEG audio frame header decoder
// Checks the sync bits of a 32-bit frame header, looks up bitrate and sample
// rate and computes the frame length in bytes in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, header_word) carries one header
//   word per beat, first header byte in bits 31 to 24. The output channel
//   (out_valid, out_ready, frame_bytes, bitrate_kbps, sample_rate_hz,
//   header_ok) returns one result beat per header, in order.
//   Throughput is one header per cycle: each of the five stages holds one
//   item, and a new header enters every cycle while out_ready is high.
//   Stage 1 decodes the fields and does the table lookups, stage 2 forms the
//   numerator bitrate times multiplier, stage 3 multiplies by the reciprocal
//   of the sample rate, stage 4 multiplies the quotient estimate back by the
//   rate, and stage 5 corrects the estimate by one, adds padding and scales
//   Layer I lengths by four into the output register.
//   A synchronous reset on rst empties every stage; results in flight are
//   dropped. When the receiver stalls, the whole pipeline holds and in_ready
//   falls until the waiting result is taken, so nothing is lost or repeated.
//   A header whose sync bits are not all set, or whose sample rate is
//   reserved, yields header_ok low and a frame length of zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_frame_length_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] header_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      frame_bytes,
  output logic [8:0]       bitrate_kbps,
  output logic [15:0]      sample_rate_hz,
  output logic             header_ok
);

  // Side information that travels with each item through the pipeline.
  typedef struct packed {
    logic [mafl_pkg::KBPS_W-1:0] kbps;
    logic [mafl_pkg::HZ_W-1:0]   hz;
    logic                        pad;
    logic                        layer1;
    logic                        ok;
  } side_t;

  // The pipeline advances as a whole whenever the output slot is free or
  // being emptied in this cycle.
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  logic v1, v2, v3, v4;
  side_t side1, side2, side3, side4;

  logic [mafl_pkg::MULT_W-1:0]  mult1;
  logic [mafl_pkg::RECIP_W-1:0] recip1, recip2;
  logic [mafl_pkg::NUM_W-1:0]   num2, num3, num4;
  logic [mafl_pkg::QUOT_W-1:0]  quot3, quot4;
  logic [mafl_pkg::NUM_W-1:0]   back4;

  // Stage 1 decode.
  logic [1:0] ver_c, lay_c, fidx_c;
  logic [3:0] bidx_c;
  logic       sync_c;
  side_t      side1_next;
  logic [mafl_pkg::MULT_W-1:0]  mult1_next;
  logic [mafl_pkg::RECIP_W-1:0] recip1_next;

  always_comb begin
    ver_c  = header_word[20:19];
    lay_c  = header_word[18:17];
    bidx_c = header_word[15:12];
    fidx_c = header_word[11:10];
    sync_c = (header_word & mafl_pkg::SYNC_MASK) == mafl_pkg::SYNC_MASK;

    side1_next.pad    = header_word[9];
    side1_next.layer1 = (lay_c == mafl_pkg::LAYER_I);
    if (sync_c) begin
      side1_next.kbps = mafl_pkg::lookup_kbps(ver_c, lay_c, bidx_c);
      side1_next.hz   = mafl_pkg::HZ_TAB[ver_c][fidx_c];
      recip1_next     = mafl_pkg::RECIP_TAB[ver_c][fidx_c];
    end else begin
      side1_next.kbps = '0;
      side1_next.hz   = '0;
      recip1_next     = '0;
    end
    side1_next.ok = (side1_next.hz != '0);

    if (lay_c == mafl_pkg::LAYER_I) begin
      mult1_next = mafl_pkg::MULT_L1;
    end else if (lay_c == mafl_pkg::LAYER_II || ver_c == mafl_pkg::VER_MPEG1) begin
      mult1_next = mafl_pkg::MULT_1152;
    end else begin
      mult1_next = mafl_pkg::MULT_576;
    end
  end

  // Arithmetic for stages 2 to 5.
  localparam int BACK_W = mafl_pkg::QUOT_W + mafl_pkg::HZ_W;
  localparam int NUMF_W = mafl_pkg::KBPS_W + mafl_pkg::MULT_W;

  logic [NUMF_W-1:0]            num_full_c;
  logic [mafl_pkg::PROD_W-1:0]  prod_c;
  logic [BACK_W-1:0]            back_full_c;
  logic [mafl_pkg::NUM_W-1:0]   rem_c;
  logic [mafl_pkg::QUOT_W-1:0]  quot_fix_c, quot_pad_c;
  logic [mafl_pkg::LEN_W-1:0]   len_c;

  always_comb begin
    num_full_c  = NUMF_W'(side1.kbps) * NUMF_W'(mult1);
    prod_c      = mafl_pkg::PROD_W'(num2) * mafl_pkg::PROD_W'(recip2);
    back_full_c = BACK_W'(quot3) * BACK_W'(side3.hz);
    // The estimate never exceeds the true quotient, so the remainder is
    // non-negative and at most one more rate step is missing.
    rem_c       = num4 - back4;
    quot_fix_c  = quot4 + mafl_pkg::QUOT_W'(rem_c >= mafl_pkg::NUM_W'(side4.hz));
    quot_pad_c  = quot_fix_c + mafl_pkg::QUOT_W'(side4.pad);
    if (!side4.ok) begin
      len_c = '0;
    end else if (side4.layer1) begin
      len_c = {quot_pad_c[mafl_pkg::LEN_W-3:0], 2'b00};
    end else begin
      len_c = quot_pad_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side1  <= side1_next;
      mult1  <= mult1_next;
      recip1 <= recip1_next;

      side2  <= side1;
      num2   <= num_full_c[mafl_pkg::NUM_W-1:0];
      recip2 <= recip1;

      side3  <= side2;
      num3   <= num2;
      quot3  <= prod_c[mafl_pkg::DIV_SHIFT +: mafl_pkg::QUOT_W];

      side4  <= side3;
      num4   <= num3;
      quot4  <= quot3;
      back4  <= back_full_c[mafl_pkg::NUM_W-1:0];

      frame_bytes    <= len_c;
      bitrate_kbps   <= side4.kbps;
      sample_rate_hz <= side4.hz;
      header_ok      <= side4.ok;
    end
  end

  // A rejected header never reports a length.
  a_bad_no_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !header_ok) |-> (frame_bytes == '0))
    else $error("frame length reported for a rejected header");

  // header_ok follows a valid sample rate exactly.
  a_ok_matches_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_ok == (sample_rate_hz != '0)))
    else $error("header_ok disagrees with sample rate");

  // The longest legal frame is 2881 bytes.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_bytes <= 12'd2881))
    else $error("frame length out of range");

  // A stage that holds during a stall keeps its valid bit.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!advance && v4) |=> v4)
    else $error("pipeline item lost during stall");

endmodule

`default_nettype wire

/* tb/sv/mpeg_audio_frame_length_top_tb.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_length_top_tb: self-checking bench for the frame decoder
// Drives 32-bit MPEG audio frame headers into the block, predicts frame
// length, bitrate, sample rate and the header flag for each accepted beat, and
// checks every result beat in order. Both channels idle at random, with one
// long receiver hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_length_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The two-bit sample rate index value that has no rate behind it.
  localparam logic [1:0] RATE_IDX_RSV = 2'd3;

  // Bitrate codes that carry no table bitrate.
  localparam logic [3:0] KBPS_IDX_FREE = 4'd0;
  localparam logic [3:0] KBPS_IDX_BAD  = 4'd15;

  localparam int RANDOM_ITEMS  = 1625;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 36;
  localparam int REPORT_MAX    = 10;

  // One predicted result beat.
  typedef struct packed {
    logic [11:0] frame_bytes;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        header_ok;
  } frame_info_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] header_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] frame_bytes;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic        header_ok;

  mpeg_audio_frame_length_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .header_word    (header_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_bytes    (frame_bytes),
    .bitrate_kbps   (bitrate_kbps),
    .sample_rate_hz (sample_rate_hz),
    .header_ok      (header_ok)
  );

  // Bitrate rows: MPEG-1 Layer I, II, III, then MPEG-2/2.5 Layer I, then
  // MPEG-2/2.5 Layers II and III.
  int unsigned kbps_rows [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  // MPEG-1 sample rates; MPEG-2 halves them and MPEG-2.5 quarters them.
  int unsigned mpeg1_hz [3] = '{44100, 48000, 32000};

  logic [31:0]  pending_headers [$];
  frame_info_t  expected_frames [$];
  int           accepted_headers = 0;
  int           checked_frames = 0;
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  int           total_headers;

  // The middle of the run has a long stretch with no idling on either side.
  wire calm = (accepted_headers >= 700) && (accepted_headers < 1000);

  // Decodes one header word into the result the block should return.
  function automatic frame_info_t decode_header(input logic [31:0] hw);
    frame_info_t      r;
    logic [1:0]       ver;
    logic [1:0]       lay;
    logic [3:0]       bidx;
    logic [1:0]       sidx;
    logic             pad;
    int unsigned      row;
    longint unsigned  kbps;
    longint unsigned  hz;
    longint unsigned  spf;
    longint unsigned  len;
    r = '0;
    if ((hw & mafl_pkg::SYNC_MASK) == mafl_pkg::SYNC_MASK) begin
      ver  = hw[20:19];
      lay  = hw[18:17];
      bidx = hw[15:12];
      sidx = hw[11:10];
      pad  = hw[9];
      kbps = 0;
      if (lay != mafl_pkg::LAYER_RSV && ver != mafl_pkg::VER_RSV) begin
        if (ver == mafl_pkg::VER_MPEG1) begin
          row = (lay == mafl_pkg::LAYER_I) ? 0 : (lay == mafl_pkg::LAYER_II) ? 1 : 2;
        end else begin
          row = (lay == mafl_pkg::LAYER_I) ? 3 : 4;
        end
        kbps = kbps_rows[row][bidx];
      end
      hz = 0;
      if (ver != mafl_pkg::VER_RSV && sidx != RATE_IDX_RSV) begin
        hz = mpeg1_hz[sidx];
        if (ver == mafl_pkg::VER_MPEG2) begin
          hz = hz / 2;
        end else if (ver == mafl_pkg::VER_MPEG25) begin
          hz = hz / 4;
        end
      end
      len = 0;
      if (hz != 0) begin
        r.header_ok = 1'b1;
        if (lay == mafl_pkg::LAYER_I) begin
          len = ((12000 * kbps) / hz + pad) * 4;
        end else begin
          spf = (lay == mafl_pkg::LAYER_II || ver == mafl_pkg::VER_MPEG1) ? 1152 : 576;
          len = (125 * kbps * spf) / hz + pad;
        end
      end
      r.frame_bytes    = len[11:0];
      r.bitrate_kbps   = kbps[8:0];
      r.sample_rate_hz = hz[15:0];
    end
    return r;
  endfunction

  // Assembles a header with all sync bits set; the other bits come from junk.
  function automatic logic [31:0] make_header(input logic [31:0] junk, input logic [1:0] ver,
                                              input logic [1:0] lay, input logic [3:0] bidx,
                                              input logic [1:0] sidx, input logic pad);
    logic [31:0] hw;
    hw        = junk | mafl_pkg::SYNC_MASK;
    hw[20:19] = ver;
    hw[18:17] = lay;
    hw[15:12] = bidx;
    hw[11:10] = sidx;
    hw[9]     = pad;
    return hw;
  endfunction

  // Most random headers are well formed so that every table entry and both
  // length formulas get exercised; the rest have random fields or bad sync.
  function automatic logic [31:0] random_header();
    logic [31:0] hw;
    logic [1:0]  ver;
    int unsigned pick;
    pick = $urandom_range(99);
    hw   = $urandom();
    if (pick < 55) begin
      ver = 2'($urandom_range(3));
      if (ver == mafl_pkg::VER_RSV) begin
        ver = ($urandom_range(1) == 1) ? mafl_pkg::VER_MPEG1 : mafl_pkg::VER_MPEG2;
      end
      hw = make_header(hw, ver, 2'($urandom_range(mafl_pkg::LAYER_I, mafl_pkg::LAYER_III)),
                       4'($urandom_range(14, 1)), 2'($urandom_range(2)),
                       1'($urandom_range(1)));
    end else if (pick < 85) begin
      hw = hw | mafl_pkg::SYNC_MASK;
    end else if (pick < 93) begin
      hw = hw | mafl_pkg::SYNC_MASK;
      hw[21 + $urandom_range(10)] = 1'b0;
    end
    return hw;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("frame %0d: %s expected %0d, got %0d", checked_frames, field, want, got);
    end
  endtask

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the next header from the pending queue. A new beat is
  // loaded only when the channel is empty or the current beat is being taken
  // at this edge, so valid and the payload stay put while the block stalls.
  // Each accepted beat gets its prediction pushed onto the expected queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_frames.push_back(decode_header(header_word));
        accepted_headers <= accepted_headers + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_headers.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          header_word <= pending_headers.pop_front();
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction, and
  // decides out_ready for the next cycle. Once a few hundred results have
  // passed, the receiver holds off for a long stretch while the sender keeps
  // going, so all five stages fill and in_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("frame %0d: result beat with nothing expected", checked_frames);
          end
        end else begin
          frame_info_t want;
          want = expected_frames.pop_front();
          if (frame_bytes !== want.frame_bytes) begin
            report_mismatch("frame_bytes", want.frame_bytes, frame_bytes);
          end
          if (bitrate_kbps !== want.bitrate_kbps) begin
            report_mismatch("bitrate_kbps", want.bitrate_kbps, bitrate_kbps);
          end
          if (sample_rate_hz !== want.sample_rate_hz) begin
            report_mismatch("sample_rate_hz", want.sample_rate_hz, sample_rate_hz);
          end
          if (header_ok !== want.header_ok) begin
            report_mismatch("header_ok", want.header_ok, header_ok);
          end
        end
        checked_frames <= checked_frames + 1;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && checked_frames >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: a block that stops moving beats ends the run as a failure.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with %0d results outstanding", stall_cycles,
             expected_frames.size());
    $display("mpeg_audio_frame_length_top regression: fail");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [1:0] ver;
    logic [1:0] lay;

    // Directed part: all-zero and all-one words, broken sync at either end of
    // the sync field, then every version and layer at the top bitrate code.
    pending_headers.push_back(32'h0000_0000);
    pending_headers.push_back(32'hFFFF_FFFF);
    pending_headers.push_back(32'hFFDF_FFFF);
    pending_headers.push_back(32'h7FFF_FFFF);
    pending_headers.push_back(mafl_pkg::SYNC_MASK);
    for (int v = 0; v < 4; v++) begin
      for (int l = 0; l < 4; l++) begin
        ver = 2'(v);
        lay = 2'(l);
        pending_headers.push_back(make_header('0, ver, lay, 4'd14, 2'((v + l) % 3), lay[0]));
      end
    end
    // Longest MPEG-1 Layer II frame, longest Layer I frame at the lowest rate, the
    // free and bad bitrate codes with padding, and a reserved rate index.
    pending_headers.push_back(make_header('0, mafl_pkg::VER_MPEG1, mafl_pkg::LAYER_II,
                                          4'd14, 2'd2, 1'b1));
    pending_headers.push_back(make_header(32'h0000_01FF, mafl_pkg::VER_MPEG25,
                                          mafl_pkg::LAYER_I, 4'd14, 2'd2, 1'b1));
    pending_headers.push_back(make_header('0, mafl_pkg::VER_MPEG1, mafl_pkg::LAYER_I,
                                          KBPS_IDX_FREE, 2'd0, 1'b1));
    pending_headers.push_back(make_header('0, mafl_pkg::VER_MPEG2, mafl_pkg::LAYER_III,
                                          KBPS_IDX_BAD, 2'd1, 1'b1));
    pending_headers.push_back(make_header('0, mafl_pkg::VER_MPEG1, mafl_pkg::LAYER_III,
                                          4'd9, RATE_IDX_RSV, 1'b0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_headers.push_back(random_header());
    end
    total_headers = pending_headers.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_headers != total_headers) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    // Give the pipeline time to show any stray extra beat.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("mpeg_audio_frame_length_top regression: pass");
    end else begin
      $display("mpeg_audio_frame_length_top regression: fail");
    end
    $finish;
  end

endmodule
